@@ hdl/assert_macros.svh @@
// Assertion macros shared by the budget limiter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property violated");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property violated");

`endif

@@ hdl/pbl_pkg.sv @@
// Types and constants shared by the budget limiter modules.
package pbl_pkg;

    localparam int LimitW  = 40;
    localparam int WarnW   = 17;
    localparam int PeriodW = 32;
    localparam int CostW   = 32;
    localparam int LifeW   = 47;
    localparam int CountW  = 32;
    localparam int ThrW    = 57;
    localparam int PpW     = 37;
    localparam int HalfW   = 20;
    localparam int OutW    = 242;
    localparam int OutPadW = 248;

    localparam logic [LimitW-1:0]  LimitReset  = 40'd1000000;
    localparam logic [WarnW-1:0]   WarnReset   = 17'd52429;
    localparam logic [PeriodW-1:0] PeriodReset = 32'd60;
    localparam logic [LifeW-1:0]   Lim100Reset = 47'd100000000;
    localparam logic [PpW-1:0]     PpLoReset   = 37'd52429000000;
    localparam logic [ThrW-1:0]    ThrReset    = 57'd52429000000;
    localparam logic [WarnW-1:0]   WarnOne     = 17'd65536;

    typedef enum logic [1:0] {
        CMD_CONSUME = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RESET   = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        VERDICT_OK     = 2'd0,
        VERDICT_WARN   = 2'd1,
        VERDICT_DENIED = 2'd2,
        VERDICT_NONE   = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        LEVEL_NORMAL = 2'd0,
        LEVEL_WARN   = 2'd1,
        LEVEL_LIMIT  = 2'd2
    } t_level;

    typedef enum logic [1:0] {
        CFG_LIMIT  = 2'd0,
        CFG_WARN   = 2'd1,
        CFG_PERIOD = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take_in;
        logic apply;
        logic div_start;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic consume_ok;
        logic div_done;
    } t_dp_sts;

endpackage

@@ hdl/pbl_div.sv @@
// Restoring serial divider: one quotient bit per cycle for the mean cost.
`include "assert_macros.svh"
module pbl_div
    import pbl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [LifeW-1:0]  i_dividend,
    input  logic [CountW-1:0] i_divisor,
    output logic              o_done,
    output logic [LifeW-1:0]  o_quot
);

    localparam int CntW = $clog2(LifeW);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic [CountW-1:0] r_rem, n_rem;
    logic [LifeW-1:0]  r_quo, n_quo;
    logic [CountW-1:0] r_dvs, n_dvs;
    logic [CountW:0]   trial;
    logic [CountW:0]   diff;

    always_comb begin
        trial  = {r_rem, r_quo[LifeW-1]};
        diff   = trial - {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CntW'(LifeW - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff[CountW-1:0];
                n_quo = {r_quo[LifeW-2:0], 1'b1};
            end else begin
                n_rem = trial[CountW-1:0];
                n_quo = {r_quo[LifeW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    `ASSERT_NEXT(a_div_last_step, i_clk, i_rst_n, r_busy && !i_start && r_cnt == '0, !r_busy && r_done)

endmodule

@@ hdl/pbl_ctrl.sv @@
// Controller state machine: sequences accept, update, divide and output load.
`include "assert_macros.svh"
module pbl_ctrl
    import pbl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   s_fire;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_ovalid = r_ovalid;
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    o_cmd.take_in = 1'b1;
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.consume_ok) begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // The output register is free, or its transfer completes now.
                if (!r_ovalid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    `ASSERT_NEXT(a_take_then_apply, i_clk, i_rst_n, s_fire, r_state == ST_APPLY)
    `ASSERT_IMPLIES(a_div_only_on_ok, i_clk, i_rst_n, o_cmd.div_start, i_sts.consume_ok)

endmodule

@@ hdl/pbl_dp.sv @@
// Datapath: configuration, window and lifetime state, compares and result register.
`include "assert_macros.svh"
module pbl_dp
    import pbl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [CostW-1:0]   i_s_tdata,
    input  logic [1:0]         i_s_tuser,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [LimitW-1:0]  i_cfg_data,
    output logic [OutPadW-1:0] o_m_tdata
);

    logic [LimitW-1:0]  r_limit;
    logic [WarnW-1:0]   r_warn;
    logic [PeriodW-1:0] r_period;
    logic [LifeW-1:0]   r_lim100;
    logic [PpW-1:0]     r_pp_lo, r_pp_hi;
    logic [ThrW-1:0]    r_thr;

    t_cmd               r_cmd;
    logic [CostW-1:0]   r_cost;
    logic [LimitW-1:0]  r_win;
    logic [LifeW-1:0]   r_life;
    logic [PeriodW-1:0] r_ticks;
    logic [CountW-1:0]  r_acc;
    logic [CountW-1:0]  r_deny;
    logic [LifeW-1:0]   r_mean;
    logic               r_ok;
    t_verdict           r_vkind;
    logic [OutW-1:0]    r_out;

    logic               roll;
    logic [LimitW-1:0]  win0;
    logic [LimitW:0]    new_win;
    logic [LifeW:0]     new_life;
    logic               deny;
    logic               div_done;
    logic [LifeW-1:0]   quot;
    logic [ThrW-1:0]    win_scaled;
    logic               warn_ge, warn_gt;
    t_level             level;
    t_verdict           verdict;
    logic [LimitW-1:0]  remaining;

    // Limit-derived values are registered: lim100 and the products, then thr from them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LimitReset;
            r_warn   <= WarnReset;
            r_period <= PeriodReset;
            r_lim100 <= Lim100Reset;
            r_pp_lo  <= PpLoReset;
            r_pp_hi  <= '0;
            r_thr    <= ThrReset;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_LIMIT: begin
                        if (i_cfg_data != '0) begin
                            r_limit <= i_cfg_data;
                        end
                    end
                    CFG_WARN: begin
                        if (i_cfg_data[WarnW-1:0] != '0 && i_cfg_data[WarnW-1:0] <= WarnOne) begin
                            r_warn <= i_cfg_data[WarnW-1:0];
                        end
                    end
                    CFG_PERIOD: begin
                        r_period <= i_cfg_data[PeriodW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // Times 100 as 64 + 32 + 4.
            r_lim100 <= ({7'd0, r_limit} << 6) + ({7'd0, r_limit} << 5)
                      + ({7'd0, r_limit} << 2);
            r_pp_lo  <= PpW'(r_limit[HalfW-1:0]) * PpW'(r_warn);
            r_pp_hi  <= PpW'(r_limit[LimitW-1:HalfW]) * PpW'(r_warn);
            r_thr    <= {r_pp_hi, {HalfW{1'b0}}} + {{HalfW{1'b0}}, r_pp_lo};
        end
    end

    always_comb begin
        roll     = (r_ticks >= r_period);
        win0     = roll ? '0 : r_win;
        new_win  = {1'b0, win0} + {{(LimitW-CostW+1){1'b0}}, r_cost};
        new_life = {1'b0, r_life} + {{(LifeW-CostW+1){1'b0}}, r_cost};
        deny     = (new_win > {1'b0, r_limit}) || (new_life > {1'b0, r_lim100});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_life  <= '0;
            r_ticks <= '0;
            r_acc   <= '0;
            r_deny  <= '0;
            r_mean  <= '0;
            r_ok    <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_ok <= 1'b0;
                if (r_cmd == CMD_TICK) begin
                    if (r_ticks != '1) begin
                        r_ticks <= r_ticks + 1'b1;
                    end
                end else begin
                    if (roll) begin
                        r_win   <= '0;
                        r_ticks <= '0;
                    end
                    if (r_cmd == CMD_RESET) begin
                        r_win   <= '0;
                        r_ticks <= '0;
                    end else if (r_cmd == CMD_CONSUME) begin
                        if (deny) begin
                            if (r_deny != '1) begin
                                r_deny <= r_deny + 1'b1;
                            end
                        end else begin
                            r_win  <= new_win[LimitW-1:0];
                            r_life <= new_life[LifeW-1:0];
                            if (r_acc != '1) begin
                                r_acc <= r_acc + 1'b1;
                            end
                            r_ok <= 1'b1;
                        end
                    end
                end
            end
            if (div_done) begin
                r_mean <= quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_cmd  <= t_cmd'(i_s_tuser);
            r_cost <= i_s_tdata;
        end
        if (i_cmd.apply) begin
            if (r_cmd != CMD_CONSUME) begin
                r_vkind <= VERDICT_NONE;
            end else if (deny) begin
                r_vkind <= VERDICT_DENIED;
            end else begin
                r_vkind <= VERDICT_OK;
            end
        end
        if (i_cmd.load_out) begin
            r_out <= {r_mean, r_deny, r_acc, r_life, r_win, remaining, level, verdict};
        end
    end

    pbl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_life),
        .i_divisor  (r_acc),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Warning compares run exactly as window * 65536 against limit * fraction.
    always_comb begin
        win_scaled = {1'b0, r_win, 16'd0};
        warn_ge    = (win_scaled >= r_thr);
        warn_gt    = (win_scaled > r_thr);
        if (r_win >= r_limit) begin
            level = LEVEL_LIMIT;
        end else if (warn_ge) begin
            level = LEVEL_WARN;
        end else begin
            level = LEVEL_NORMAL;
        end
        if (r_vkind == VERDICT_OK && warn_gt) begin
            verdict = VERDICT_WARN;
        end else begin
            verdict = r_vkind;
        end
        remaining = (r_limit > r_win) ? (r_limit - r_win) : '0;
    end

    assign o_sts.consume_ok = r_ok;
    assign o_sts.div_done   = div_done;
    assign o_m_tdata        = {{(OutPadW-OutW){1'b0}}, r_out};

    `ASSERT_NEXT(a_win_within_limit, i_clk, i_rst_n, i_cmd.apply && r_cmd == CMD_CONSUME && !deny, r_win <= r_limit)
    `ASSERT_NEXT(a_deny_monotonic, i_clk, i_rst_n, 1'b1, r_deny >= $past(r_deny))

endmodule

@@ hdl/periodic_budget_limiter_unit.sv @@
// Top level of the fixed-window budget limiter: controller plus datapath.
//
//  Channel   Direction  Payload
//  s (item)  in         tuser: cmd; tdata: cost
//  m (res)   out        tdata: verdict, level, remaining, sums, counts, mean
//  cfg       in         index 0 limit, 1 warn fraction, 2 period; data
//
// A tick, reset, query or denied consume loads its result after apply, check and done.
// An accepted consume loads its result after apply, check, 47 serial divider steps
// and the done state; the divider sets the item time.
// The next item can transfer in the cycle after the load, even while the result waits.
// Output stalls hold the finished result; the next item then waits in the controller.
// Reset is synchronous, active low, and restores the default register values.
`include "assert_macros.svh"
module periodic_budget_limiter_unit
    import pbl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [CostW-1:0]   i_s_tdata,   // [31:0] cost
    input  logic [1:0]         i_s_tuser,   // [1:0] cmd
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // [1:0] verdict, [3:2] level, [43:4] remaining, [83:44] window_sum,
    // [130:84] lifetime_sum, [162:131] accepted_requests,
    // [194:163] denied_requests, [241:195] mean_cost, [247:242] zero
    output logic [OutPadW-1:0] o_m_tdata,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [LimitW-1:0]  i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    pbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    pbl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tdata   (o_m_tdata)
    );

    `ASSERT_IMPLIES(a_load_only_in_idle_exit, i_clk, i_rst_n, dp_cmd.load_out, !o_s_tready)

endmodule

@@ test/periodic_budget_limiter_unit_tb.sv @@
// Self-checking testbench for the fixed-window budget limiter with a built-in predictor.
`timescale 1ns / 1ps

module periodic_budget_limiter_unit_tb
    import pbl_pkg::*;
();

    localparam logic [1:0] CfgUnused   = 2'd3;
    localparam int         DrainCycles = 64;

    // Packed in the order of the result tdata, lowest field last.
    typedef struct packed {
        logic [OutPadW-OutW-1:0] pad;
        logic [LifeW-1:0]        mean_cost;
        logic [CountW-1:0]       denied_requests;
        logic [CountW-1:0]       accepted_requests;
        logic [LifeW-1:0]        lifetime_sum;
        logic [LimitW-1:0]       window_sum;
        logic [LimitW-1:0]       remaining;
        t_level                  level;
        t_verdict                verdict;
    } t_budget_status;

    class limiter_ledger;
        logic [LimitW-1:0]  limit_r;
        logic [WarnW-1:0]   warn_r;
        logic [PeriodW-1:0] period_r;
        logic [LimitW-1:0]  window_total;
        logic [LifeW-1:0]   lifetime_total;
        logic [PeriodW-1:0] ticks;
        logic [CountW-1:0]  ok_count;
        logic [CountW-1:0]  deny_count;
        logic [LifeW-1:0]   mean_cost;
        t_budget_status     pending_status[$];
        int                 errors;

        function new();
            limit_r        = LimitReset;
            warn_r         = WarnReset;
            period_r       = PeriodReset;
            window_total   = '0;
            lifetime_total = '0;
            ticks          = '0;
            ok_count       = '0;
            deny_count     = '0;
            mean_cost      = '0;
            errors         = 0;
        endfunction

        // Out-of-range limit or warning values leave the register unchanged.
        function void write_reg(logic [1:0] idx, logic [LimitW-1:0] data);
            unique case (idx)
                CFG_LIMIT: begin
                    if (data != '0) limit_r = data;
                end
                CFG_WARN: begin
                    if (data[WarnW-1:0] != '0 && data[WarnW-1:0] <= WarnOne)
                        warn_r = data[WarnW-1:0];
                end
                CFG_PERIOD: begin
                    period_r = data[PeriodW-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void record_item(t_cmd cmd, logic [CostW-1:0] cost);
            logic [63:0]    grown_window;
            logic [63:0]    grown_life;
            logic [63:0]    warn_mark;
            t_budget_status st;
            st.verdict = VERDICT_NONE;
            warn_mark  = 64'(limit_r) * 64'(warn_r);
            if (cmd == CMD_TICK) begin
                if (ticks != '1) ticks = ticks + 1'b1;
            end else begin
                if (ticks >= period_r) begin
                    window_total = '0;
                    ticks        = '0;
                end
                if (cmd == CMD_RESET) begin
                    window_total = '0;
                    ticks        = '0;
                end else if (cmd == CMD_CONSUME) begin
                    grown_window = 64'(window_total) + 64'(cost);
                    grown_life   = 64'(lifetime_total) + 64'(cost);
                    if (grown_window > 64'(limit_r) ||
                        grown_life > 64'(limit_r) * 64'd100) begin
                        if (deny_count != '1) deny_count = deny_count + 1'b1;
                        st.verdict = VERDICT_DENIED;
                    end else begin
                        window_total   = grown_window[LimitW-1:0];
                        lifetime_total = grown_life[LifeW-1:0];
                        if (ok_count != '1) ok_count = ok_count + 1'b1;
                        mean_cost  = lifetime_total / LifeW'(ok_count);
                        // The accept warning is strict, the level warning below is not.
                        st.verdict = ((64'(window_total) << 16) > warn_mark) ?
                                     VERDICT_WARN : VERDICT_OK;
                    end
                end
            end
            if (window_total >= limit_r)
                st.level = LEVEL_LIMIT;
            else if ((64'(window_total) << 16) >= warn_mark)
                st.level = LEVEL_WARN;
            else
                st.level = LEVEL_NORMAL;
            st.remaining         = (limit_r > window_total) ? limit_r - window_total : '0;
            st.window_sum        = window_total;
            st.lifetime_sum      = lifetime_total;
            st.accepted_requests = ok_count;
            st.denied_requests   = deny_count;
            st.mean_cost         = mean_cost;
            st.pad               = '0;
            pending_status.push_back(st);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_status(logic [OutPadW-1:0] data);
            t_budget_status got;
            t_budget_status want;
            if (pending_status.size() == 0) begin
                $error("result transfer with no item outstanding");
                errors++;
                return;
            end
            got  = data;
            want = pending_status.pop_front();
            compare("verdict", want.verdict, got.verdict);
            compare("level", want.level, got.level);
            compare("remaining", want.remaining, got.remaining);
            compare("window_sum", want.window_sum, got.window_sum);
            compare("lifetime_sum", want.lifetime_sum, got.lifetime_sum);
            compare("accepted_requests", want.accepted_requests, got.accepted_requests);
            compare("denied_requests", want.denied_requests, got.denied_requests);
            compare("mean_cost", want.mean_cost, got.mean_cost);
            compare("pad", want.pad, got.pad);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [CostW-1:0]   i_s_tdata;
    logic [1:0]         i_s_tuser;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [OutPadW-1:0] o_m_tdata;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [LimitW-1:0]  i_cfg_data;

    int tx_idle_pct;
    int rx_idle_pct;

    limiter_ledger ledger = new();

    periodic_budget_limiter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("periodic_budget_limiter_unit_tb NOT OK");
        $finish;
    end

    // Result side: check every transfer, then pick the next ready at random.
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) ledger.check_status(o_m_tdata);
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic wait_drained();
        while (ledger.pending_status.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Valid stays high after the last write unless it closes the group.
    task automatic write_reg(input logic [1:0] idx, input logic [LimitW-1:0] data,
                             input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.write_reg(idx, data);
        if (last) i_cfg_valid <= 1'b0;
    endtask

    // Bits above each register's width carry random junk that must be dropped.
    task automatic set_regs(input logic [LimitW-1:0] limit, input logic [WarnW-1:0] warn,
                            input logic [PeriodW-1:0] period);
        write_reg(CFG_LIMIT, limit, 1'b0);
        write_reg(CFG_WARN, {23'($urandom), warn}, 1'b0);
        write_reg(CFG_PERIOD, {8'($urandom), period}, 1'b1);
    endtask

    task automatic drive_item(input t_cmd cmd, input logic [CostW-1:0] cost);
        int gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= cost;
        do @(posedge i_clk); while (!o_s_tready);
        ledger.record_item(cmd, cost);
    endtask

    task automatic end_items();
        i_s_tvalid <= 1'b0;
        wait_drained();
    endtask

    task automatic run_random(input int count, input logic [CostW-1:0] cost_max);
        int               r;
        t_cmd             cmd;
        logic [CostW-1:0] cost;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 50)
                cmd = CMD_CONSUME;
            else if (r < 80)
                cmd = CMD_TICK;
            else if (r < 85)
                cmd = CMD_RESET;
            else
                cmd = CMD_QUERY;
            if (cost_max == '1 || $urandom_range(15) == 0)
                cost = $urandom;
            else
                cost = $urandom_range(cost_max, 0);
            drive_item(cmd, cost);
        end
        end_items();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= CMD_CONSUME;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_LIMIT;
        i_cfg_data  <= '0;
        tx_idle_pct = 25;
        rx_idle_pct = 47;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values first, then writes that must all be ignored.
        drive_item(CMD_QUERY, $urandom);
        end_items();
        write_reg(CFG_LIMIT, '0, 1'b0);
        write_reg(CFG_WARN, 40'd0, 1'b0);
        write_reg(CFG_WARN, 40'd65537, 1'b0);
        write_reg(CFG_WARN, 40'h1FFFF, 1'b0);
        write_reg(CfgUnused, '1, 1'b1);
        drive_item(CMD_QUERY, '0);
        end_items();

        // Limit 100 with the warning mark at exactly 50.
        set_regs(40'd100, 17'd32768, 32'd3);
        drive_item(CMD_CONSUME, 32'd50);
        drive_item(CMD_CONSUME, 32'd1);
        drive_item(CMD_CONSUME, 32'd49);
        drive_item(CMD_CONSUME, 32'd0);
        drive_item(CMD_CONSUME, 32'd1);
        drive_item(CMD_CONSUME, 32'hFFFF_FFFF);
        drive_item(CMD_TICK, 32'hFFFF_FFFF);
        drive_item(CMD_TICK, 32'd0);
        drive_item(CMD_TICK, 32'd7);
        drive_item(CMD_QUERY, 32'd0);
        drive_item(CMD_CONSUME, 32'd0);
        drive_item(CMD_CONSUME, 32'd70);
        drive_item(CMD_RESET, 32'd5);
        drive_item(CMD_TICK, 32'd0);
        drive_item(CMD_CONSUME, 32'd30);
        end_items();

        // With a zero period every non-tick item starts a fresh window.
        set_regs(40'd100, 17'd32768, 32'd0);
        drive_item(CMD_CONSUME, 32'd20);
        drive_item(CMD_QUERY, 32'd0);
        drive_item(CMD_CONSUME, 32'd100);
        drive_item(CMD_CONSUME, 32'd101);
        end_items();

        // Smallest limit: the lifetime bound is already exceeded.
        set_regs(40'd1, WarnOne, 32'd0);
        drive_item(CMD_CONSUME, 32'd0);
        drive_item(CMD_QUERY, 32'd0);
        drive_item(CMD_TICK, 32'd0);
        end_items();

        // Tiny limit so the lifetime bound is reached during the phase.
        set_regs(40'd10, 17'd1, 32'd0);
        run_random(500, 32'd12);

        // Fill a long window, then lower the limit below its sum.
        set_regs(40'd2000, 17'd60000, 32'd1000);
        run_random(200, 32'd100);
        tx_idle_pct = 47;
        rx_idle_pct = 25;
        set_regs(40'd500, 17'd65535, 32'd1000);
        run_random(300, 32'd60);

        set_regs(40'd1000000, 17'd52429, 32'd60);
        run_random(600, 32'd200000);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_regs('1, WarnOne, '1);
        run_random(400, '1);

        repeat (DrainCycles) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending_status.size() == 0) begin
            $display("periodic_budget_limiter_unit_tb OK");
        end else begin
            $display("periodic_budget_limiter_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/pbl_pkg.sv
hdl/pbl_div.sv
hdl/pbl_ctrl.sv
hdl/pbl_dp.sv
hdl/periodic_budget_limiter_unit.sv
test/periodic_budget_limiter_unit_tb.sv
